>>> src/ars_pkg.sv
// shared types and constants for the affine residual statistics block
package ars_pkg;

  localparam int unsigned FracBits  = 16;
  localparam int unsigned MaxPoints = 65536;
  localparam int unsigned CntW      = $clog2(MaxPoints + 1);
  localparam int unsigned QDepth    = 2;

  // configuration register indexes
  localparam logic [2:0] RegXLon = 3'd0;
  localparam logic [2:0] RegXLat = 3'd1;
  localparam logic [2:0] RegXOff = 3'd2;
  localparam logic [2:0] RegYLon = 3'd3;
  localparam logic [2:0] RegYLat = 3'd4;
  localparam logic [2:0] RegYOff = 3'd5;

  // squared distance handed from front to back
  typedef struct packed {
    logic [63:0] sq;
    logic        huge;
    logic        last;
  } ars_item_t;

  typedef struct packed {
    logic [31:0] point_error;
    logic        stats_valid;
    logic [31:0] rms_error;
    logic [31:0] mean_error;
    logic [31:0] min_error;
    logic [31:0] max_error;
  } ars_result_t;

endpackage

>>> src/ars_front.sv
// front part: affine prediction and squared distance, one multiply per cycle
module ars_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic signed [31:0]  coef_i [6],
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [31:0]         lat_i,
  input  logic [31:0]         lon_i,
  input  logic [31:0]         tx_i,
  input  logic [31:0]         ty_i,
  input  logic                last_i,
  output logic                q_valid_o,
  input  logic                q_ready_i,
  output ars_pkg::ars_item_t  q_item_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StSq   = 3'd2;
  localparam logic [2:0] StOut  = 3'd3;

  logic [2:0]         state_q, state_d;
  logic [2:0]         step_q, step_d;
  logic signed [31:0] lat_q, lon_q;
  logic               last_q;
  logic signed [65:0] dx_q, dy_q, dx_d, dy_d;
  logic [63:0]        sq_q, sq_d;
  logic               huge_q, huge_d;
  logic signed [63:0] prod;
  logic signed [31:0] ma, mb;
  logic [65:0]        ax, ay;
  logic [63:0]        usq;
  logic [64:0]        ssum;

  // multiplier operand selection per step
  always_comb begin
    ma = coef_i[ars_pkg::RegXLon];
    mb = lon_q;
    case (step_q)
      3'd0: begin ma = coef_i[ars_pkg::RegXLon]; mb = lon_q; end
      3'd1: begin ma = coef_i[ars_pkg::RegXLat]; mb = lat_q; end
      3'd2: begin ma = coef_i[ars_pkg::RegYLon]; mb = lon_q; end
      3'd3: begin ma = coef_i[ars_pkg::RegYLat]; mb = lat_q; end
      default: begin ma = coef_i[ars_pkg::RegXLon]; mb = lon_q; end
    endcase
  end
  assign prod = ma * mb;

  assign ax = dx_q[65] ? 66'(-dx_q) : dx_q;
  assign ay = dy_q[65] ? 66'(-dy_q) : dy_q;
  assign usq = (step_q == 3'd0) ? ax[31:0] * ax[31:0] : ay[31:0] * ay[31:0];
  assign ssum = {1'b0, sq_q} + {1'b0, usq};

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    dx_d    = dx_q;
    dy_d    = dy_q;
    sq_d    = sq_q;
    huge_d  = huge_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StMul;
          step_d  = 3'd0;
        end
      end
      StMul: begin
        // accumulate floor-shifted products
        if (step_q < 3'd2) begin
          dx_d = dx_q + 66'(prod >>> ars_pkg::FracBits);
        end else begin
          dy_d = dy_q + 66'(prod >>> ars_pkg::FracBits);
        end
        step_d = step_q + 3'd1;
        if (step_q == 3'd3) begin
          state_d = StSq;
          step_d  = 3'd0;
        end
      end
      StSq: begin
        if (step_q == 3'd0) begin
          huge_d = (|ax[65:32]) | (|ay[65:32]);
          sq_d   = usq;
          step_d = 3'd1;
        end else begin
          huge_d  = huge_q | ssum[64];
          sq_d    = ssum[63:0];
          state_d = StOut;
        end
      end
      StOut: begin
        if (q_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= 3'd0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // payload registers, seeded with offset minus true position
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) begin
      lat_q  <= lat_i;
      lon_q  <= lon_i;
      last_q <= last_i;
      dx_q   <= 66'(signed'(coef_i[ars_pkg::RegXOff])) - 66'(signed'(tx_i));
      dy_q   <= 66'(signed'(coef_i[ars_pkg::RegYOff])) - 66'(signed'(ty_i));
    end else begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
    sq_q   <= sq_d;
    huge_q <= huge_d;
  end

  assign in_ready_o     = (state_q == StIdle);
  assign q_valid_o      = (state_q == StOut);
  assign q_item_o.sq    = huge_q ? '1 : sq_q;
  assign q_item_o.huge  = huge_q;
  assign q_item_o.last  = last_q;

endmodule

>>> src/ars_queue.sv
// short queue between front and back
module ars_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ars_pkg::ars_item_t in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ars_pkg::ars_item_t out_item_o
);

  localparam int unsigned PtrW = $clog2(ars_pkg::QDepth);

  ars_pkg::ars_item_t mem_q [ars_pkg::QDepth];
  logic [PtrW-1:0]    wr_q, rd_q;
  logic [PtrW:0]      cnt_q;
  logic               push, pop;

  assign in_ready_o  = (cnt_q != (PtrW+1)'(ars_pkg::QDepth));
  assign out_valid_o = (cnt_q != '0);
  assign push        = in_valid_i & in_ready_o;
  assign pop         = out_valid_o & out_ready_i;
  assign out_item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_item_i;
  end

endmodule

>>> src/ars_back.sv
// back part: root, statistics, mean and rms with bit-serial units
module ars_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  output logic                 q_ready_o,
  input  ars_pkg::ars_item_t   q_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ars_pkg::ars_result_t out_res_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRoot = 3'd1;
  localparam logic [2:0] StAcc  = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StRms  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [6:0]  it_q;
  logic [63:0] item_sq_q;
  logic        last_q;
  // root unit, two bits per cycle
  logic [63:0] rrem_q;
  logic [65:0] racc_q;
  logic [31:0] root_q;
  logic [65:0] rtrial;
  // divider, one bit per cycle; a load step then 64 steps per word
  logic [63:0] dnum_q;
  logic [63:0] dquo_q;
  logic [63:0] dquo_nx;
  logic [ars_pkg::CntW:0] drem_q;
  logic [ars_pkg::CntW:0] dshift;
  logic        qbit;
  logic        div_sel_q;
  logic [63:0] mean_q;
  logic [31:0] err_q;
  // statistics
  logic [ars_pkg::CntW-1:0] cnt_q;
  logic [47:0] esum_q;
  logic [63:0] ssum_q;
  logic [31:0] min_q, max_q;
  logic [64:0] sadd;
  logic [48:0] eadd;
  ars_pkg::ars_result_t res_q;

  assign rtrial  = {racc_q[63:0], rrem_q[63:62]} - {root_q, 2'b01};
  assign dshift  = {drem_q[ars_pkg::CntW-1:0], dnum_q[63]};
  assign qbit    = (dshift >= {1'b0, cnt_q});
  assign dquo_nx = {dquo_q[62:0], qbit};
  assign sadd    = {1'b0, ssum_q} + {1'b0, item_sq_q};
  assign eadd    = {1'b0, esum_q} + {17'd0, err_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (q_valid_i) state_d = StRoot;
      StRoot:  if (it_q == 7'd31) state_d = StAcc;
      StAcc:   state_d = last_q ? StDiv : StOut;
      StDiv:   if (it_q == 7'd64 && div_sel_q) state_d = StRms;
      StRms:   if (it_q == 7'd31) state_d = StOut;
      StOut:   if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      it_q      <= '0;
      div_sel_q <= 1'b0;
      cnt_q     <= '0;
      esum_q    <= '0;
      ssum_q    <= '0;
      min_q     <= '1;
      max_q     <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        StIdle: begin
          it_q <= '0;
          div_sel_q <= 1'b0;
        end
        StRoot: it_q <= (it_q == 7'd31) ? 7'd0 : it_q + 7'd1;
        StAcc: begin
          // statistics update, frozen once the set is full
          if (cnt_q != ars_pkg::CntW'(ars_pkg::MaxPoints)) begin
            cnt_q  <= cnt_q + 1'b1;
            esum_q <= eadd[48] ? '1 : eadd[47:0];
            ssum_q <= sadd[64] ? '1 : sadd[63:0];
            if (err_q < min_q) min_q <= err_q;
            if (err_q > max_q) max_q <= err_q;
          end
          it_q <= '0;
        end
        StDiv: begin
          if (it_q == 7'd64) begin
            it_q <= '0;
            div_sel_q <= 1'b1;
          end else begin
            it_q <= it_q + 7'd1;
          end
        end
        StRms: it_q <= it_q + 7'd1;
        StOut: begin
          if (out_ready_i && res_q.stats_valid) begin
            cnt_q  <= '0;
            esum_q <= '0;
            ssum_q <= '0;
            min_q  <= '1;
            max_q  <= '0;
          end
        end
        default: it_q <= '0;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        item_sq_q <= q_item_i.sq;
        last_q    <= q_item_i.last;
        rrem_q    <= q_item_i.sq;
        racc_q    <= '0;
        root_q    <= '0;
      end
      StRoot: begin
        rrem_q <= {rrem_q[61:0], 2'b00};
        if (!rtrial[65]) begin
          racc_q <= rtrial;
          root_q <= {root_q[30:0], 1'b1};
        end else begin
          racc_q <= {racc_q[63:0], rrem_q[63:62]};
          root_q <= {root_q[30:0], 1'b0};
        end
        if (it_q == 7'd31) begin
          err_q <= (!rtrial[65]) ? {root_q[30:0], 1'b1} : {root_q[30:0], 1'b0};
        end
      end
      StAcc: begin
        // clear the divider and stage the point result
        dnum_q <= '0;
        drem_q <= '0;
        dquo_q <= '0;
        res_q.point_error <= err_q;
        res_q.stats_valid <= last_q;
        res_q.rms_error   <= '0;
        res_q.mean_error  <= '0;
        res_q.min_error   <= '0;
        res_q.max_error   <= '0;
      end
      StDiv: begin
        if (it_q == 7'd0) begin
          dnum_q <= div_sel_q ? ssum_q : {16'd0, esum_q};
          drem_q <= '0;
        end else begin
          dnum_q <= {dnum_q[62:0], 1'b0};
          drem_q <= qbit ? dshift - {1'b0, cnt_q} : dshift;
          dquo_q <= dquo_nx;
        end
        if (it_q == 7'd64 && !div_sel_q) mean_q <= dquo_nx;
      end
      default: ;
    endcase
    if (state_q == StRms) begin
      rrem_q <= {rrem_q[61:0], 2'b00};
      if (!rtrial[65]) begin
        racc_q <= rtrial;
        root_q <= {root_q[30:0], 1'b1};
      end else begin
        racc_q <= {racc_q[63:0], rrem_q[63:62]};
        root_q <= {root_q[30:0], 1'b0};
      end
      if (it_q == 7'd31) begin
        res_q.rms_error <= (!rtrial[65]) ? {root_q[30:0], 1'b1} : {root_q[30:0], 1'b0};
        res_q.mean_error <= (mean_q[63:32] != '0) ? '1 : mean_q[31:0];
        res_q.min_error <= min_q;
        res_q.max_error <= max_q;
      end
    end
    // seed the rms root from the second quotient
    if (state_q == StDiv && it_q == 7'd64 && div_sel_q) begin
      rrem_q <= dquo_nx;
      racc_q <= '0;
      root_q <= '0;
    end
  end

  assign q_ready_o   = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign out_res_o   = res_q;

endmodule

>>> src/affine_residual_statistics.sv
// affine residual statistics: a last point, unlike an ordinary one, adds two
// divisions (mean and mean square) and a second root (rms) to its path
// the back part takes one point at a time and so limits the rate of points
// the front part overlaps the back via the queue
// reset clears all control, coefficients to zero and statistics to empty
module affine_residual_statistics (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // latitude[31:0], longitude[63:32], true_x[95:64], true_y[127:96]
  input  logic [127:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // point_error[31:0], rms[63:32], mean[95:64], min[127:96], max[159:128]
  output logic [159:0] m_axis_tdata,
  // stats_valid
  output logic         m_axis_tuser
);

  logic signed [31:0]   coef_q [6];
  logic                 fq_valid, fq_ready, bq_valid, bq_ready;
  ars_pkg::ars_item_t   f_item, b_item;
  ars_pkg::ars_result_t res;

  assign cfg_ready_o = 1'b1;

  // coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) coef_q[i] <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ars_pkg::RegXLon, ars_pkg::RegXLat, ars_pkg::RegXOff,
        ars_pkg::RegYLon, ars_pkg::RegYLat, ars_pkg::RegYOff:
          coef_q[cfg_index_i] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ars_front u_front (
    .clk_i, .rst_ni, .coef_i(coef_q),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .lat_i(s_axis_tdata[31:0]), .lon_i(s_axis_tdata[63:32]),
    .tx_i(s_axis_tdata[95:64]), .ty_i(s_axis_tdata[127:96]),
    .last_i(s_axis_tlast),
    .q_valid_o(fq_valid), .q_ready_i(fq_ready), .q_item_o(f_item)
  );

  ars_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(fq_valid), .in_ready_o(fq_ready), .in_item_i(f_item),
    .out_valid_o(bq_valid), .out_ready_i(bq_ready), .out_item_o(b_item)
  );

  ars_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(bq_valid), .q_ready_o(bq_ready), .q_item_i(b_item),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_res_o(res)
  );

  assign m_axis_tdata = {res.max_error, res.min_error, res.mean_error,
                         res.rms_error, res.point_error};
  assign m_axis_tuser = res.stats_valid;

  // summary fields are zero when no summary is flagged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[159:32] == '0)
    else $error("summary fields nonzero without stats");

  // a summary never reports min above max
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> res.min_error <= res.max_error)
    else $error("min above max");

  // a huge point always saturates its squared term
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fq_valid && f_item.huge |-> f_item.sq == '1)
    else $error("huge point not saturated");

endmodule
